FILE: rtl/mbe_pkg.sv
// shared types and constants of the mandelbrot escape-time pixel core
package mbe_pkg;

    // register and field widths
    localparam int CFG_W   = 13;
    localparam int DEN_W   = 20;
    localparam int COUNT_W = 6;
    localparam int RED_W   = 8;
    localparam int GREEN_W = 8;
    localparam int BLUE_W  = 7;

    // register reset values
    localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd1000;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd700;

    // coordinate mapping: (p*scale - offset*size) / (den_scale*size)
    localparam int X_SCALE   = 247;
    localparam int X_OFFSET  = 200;
    localparam int Y_SCALE   = 224;
    localparam int Y_OFFSET  = 112;
    localparam int DEN_SCALE = 100;

    // color ramp
    localparam int RED_SCALE   = 255;
    localparam int GREEN_SCALE = 163;
    localparam int GREEN_BASE  = 7;
    localparam int BLUE_SCALE  = 100;

    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_CHECK,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic mult;
        logic update;
    } iter_ctrl_t;

    typedef struct packed {
        logic out_of_range;
        logic escaped;
    } iter_stat_t;

endpackage

FILE: rtl/mbe_map.sv
// bit-serial pixel-to-complex coordinate mapper (restoring divider)
module mbe_map #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 26,
    parameter int SCALE      = 247,
    parameter int OFFSET     = 200
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [COORD_BITS-1:0]                 coord,
    input  logic [mbe_pkg::CFG_W-1:0]             size,
    output logic                                  busy,
    output logic signed [COORD_BITS+FRAC_BITS+2:0] value
);
    import mbe_pkg::*;

    localparam int QW    = COORD_BITS + FRAC_BITS + 2;
    localparam int MAGW  = (COORD_BITS + 8 > CFG_W + 8) ? COORD_BITS + 8 : CFG_W + 8;
    localparam int NUMW  = MAGW + FRAC_BITS;
    localparam int CNTW  = $clog2(QW + 1);

    logic              run_reg, run_next;
    logic [CNTW-1:0]   cnt_reg, cnt_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [QW-1:0]     quot_reg, quot_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic              neg_reg, neg_next;

    logic [CFG_W-1:0]  size_eff;
    logic [MAGW-1:0]   pos;
    logic [MAGW-1:0]   negp;
    logic [MAGW-1:0]   mag;
    logic              neg;
    logic [NUMW-1:0]   num;
    logic [DEN_W-1:0]  den;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    den_ext;
    logic              ge;
    logic [QW:0]       mag_q;

    // operand setup at start
    always_comb
    begin
        size_eff = (size == '0) ? CFG_W'(1) : size;
        pos      = MAGW'(coord) * MAGW'(SCALE);
        negp     = MAGW'(size_eff) * MAGW'(OFFSET);
        den      = DEN_W'(size_eff) * DEN_W'(DEN_SCALE);
        neg      = negp > pos;
        mag      = neg ? (negp - pos) : (pos - negp);
        num      = NUMW'(mag) << FRAC_BITS;
    end

    // one quotient bit per cycle
    assign den_ext = {1'b0, den_reg};
    assign trial   = {rem_reg, quot_reg[QW-1]};
    assign ge      = trial >= den_ext;

    always_comb
    begin
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = CNTW'(QW);
            // high part of the numerator is below den, so it fits
            rem_next  = DEN_W'(num >> QW);
            quot_next = num[QW-1:0];
            den_next  = den;
            neg_next  = neg;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? DEN_W'(trial - den_ext) : DEN_W'(trial);
            quot_next = {quot_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
    end

    // floor toward minus infinity on the negative side
    assign mag_q = {1'b0, quot_reg} + (QW+1)'(rem_reg != '0);
    assign value = neg_reg ? signed'(-mag_q) : signed'({1'b0, quot_reg});
    assign busy  = run_reg;

endmodule

FILE: rtl/mbe_iter.sv
// shared complex iteration unit: z = z*z + c with escape tests
module mbe_iter #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 26
) (
    input  logic                                   clk,
    input  mbe_pkg::iter_ctrl_t                    ctrl,
    input  logic signed [COORD_BITS+FRAC_BITS+2:0] cr_in,
    input  logic signed [COORD_BITS+FRAC_BITS+2:0] ci_in,
    output mbe_pkg::iter_stat_t                    stat
);
    import mbe_pkg::*;

    localparam int CW = COORD_BITS + FRAC_BITS + 3;
    localparam int ZW = CW + 1;
    localparam int MW = FRAC_BITS + 3;
    localparam int PW = 2 * MW;
    localparam int SW = FRAC_BITS + 5;

    localparam logic signed [ZW-1:0] TWO     = ZW'(1) << (FRAC_BITS + 1);
    localparam logic signed [ZW-1:0] NEG_TWO = -TWO;
    localparam logic signed [SW:0]   FOUR    = (SW+1)'(1) << (FRAC_BITS + 2);

    logic signed [CW-1:0] cr_reg, cr_next;
    logic signed [CW-1:0] ci_reg, ci_next;
    logic signed [ZW-1:0] zr_reg, zr_next;
    logic signed [ZW-1:0] zi_reg, zi_next;
    logic signed [SW-1:0] sq_r_reg, sq_r_next;
    logic signed [SW-1:0] sq_i_reg, sq_i_next;
    logic signed [SW-1:0] cross_reg, cross_next;

    logic signed [MW-1:0] zr_m;
    logic signed [MW-1:0] zi_m;
    logic signed [PW-1:0] p_rr;
    logic signed [PW-1:0] p_ii;
    logic signed [PW-1:0] p_ri;
    logic signed [PW-1:0] sh_rr;
    logic signed [PW-1:0] sh_ii;
    logic signed [PW-1:0] sh_ri;
    logic signed [SW:0]   mag2;

    // operands are within +-2 whenever a multiply is issued
    assign zr_m  = signed'(zr_reg[MW-1:0]);
    assign zi_m  = signed'(zi_reg[MW-1:0]);
    assign p_rr  = zr_m * zr_m;
    assign p_ii  = zi_m * zi_m;
    assign p_ri  = zr_m * zi_m;
    assign sh_rr = p_rr >>> FRAC_BITS;
    assign sh_ii = p_ii >>> FRAC_BITS;
    // doubling folded into the shift
    assign sh_ri = p_ri >>> (FRAC_BITS - 1);

    always_comb
    begin
        cr_next    = cr_reg;
        ci_next    = ci_reg;
        zr_next    = zr_reg;
        zi_next    = zi_reg;
        sq_r_next  = sq_r_reg;
        sq_i_next  = sq_i_reg;
        cross_next = cross_reg;
        if (ctrl.load)
        begin
            cr_next = cr_in;
            ci_next = ci_in;
            zr_next = '0;
            zi_next = '0;
        end
        if (ctrl.mult)
        begin
            sq_r_next  = signed'(sh_rr[SW-1:0]);
            sq_i_next  = signed'(sh_ii[SW-1:0]);
            cross_next = signed'(sh_ri[SW-1:0]);
        end
        if (ctrl.update)
        begin
            zr_next = ZW'(sq_r_reg) - ZW'(sq_i_reg) + ZW'(cr_reg);
            zi_next = ZW'(cross_reg) + ZW'(ci_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        cr_reg    <= cr_next;
        ci_reg    <= ci_next;
        zr_reg    <= zr_next;
        zi_reg    <= zi_next;
        sq_r_reg  <= sq_r_next;
        sq_i_reg  <= sq_i_next;
        cross_reg <= cross_next;
    end

    assign mag2 = (SW+1)'(sq_r_reg) + (SW+1)'(sq_i_reg);

    assign stat.out_of_range = (zr_reg > TWO) || (zr_reg < NEG_TWO) ||
                               (zi_reg > TWO) || (zi_reg < NEG_TWO);
    assign stat.escaped      = mag2 > FOUR;

endmodule

FILE: rtl/mbe_ramp.sv
// incremental color ramp: quotient and remainder tracked per step
module mbe_ramp #(
    parameter int MAX_ITERATIONS = 50
) (
    input  logic                          clk,
    input  logic                          init,
    input  logic                          step,
    output logic [mbe_pkg::RED_W-1:0]     red,
    output logic [mbe_pkg::GREEN_W-1:0]   green,
    output logic [mbe_pkg::BLUE_W-1:0]    blue
);
    import mbe_pkg::*;

    localparam int NW = $clog2(MAX_ITERATIONS + 1);

    localparam logic [NW:0]        LIMIT   = (NW+1)'(MAX_ITERATIONS);
    localparam logic [RED_W-1:0]   R_STEP  = RED_W'(RED_SCALE / MAX_ITERATIONS);
    localparam logic [NW:0]        R_FRAC  = (NW+1)'(RED_SCALE % MAX_ITERATIONS);
    localparam logic [GREEN_W-1:0] G_STEP  = GREEN_W'(GREEN_SCALE / MAX_ITERATIONS);
    localparam logic [NW:0]        G_FRAC  = (NW+1)'(GREEN_SCALE % MAX_ITERATIONS);
    localparam logic [BLUE_W-1:0]  B_STEP  = BLUE_W'(BLUE_SCALE / MAX_ITERATIONS);
    localparam logic [NW:0]        B_FRAC  = (NW+1)'(BLUE_SCALE % MAX_ITERATIONS);

    logic [RED_W-1:0]   red_q_reg, red_q_next;
    logic [NW-1:0]      red_rem_reg, red_rem_next;
    logic [GREEN_W-1:0] green_q_reg, green_q_next;
    logic [NW-1:0]      green_rem_reg, green_rem_next;
    logic [BLUE_W-1:0]  blue_q_reg, blue_q_next;
    logic [NW-1:0]      blue_rem_reg, blue_rem_next;

    logic [NW:0] red_sum;
    logic        red_wrap;
    logic [NW:0] green_sum;
    logic        green_wrap;
    logic        blue_borrow;

    assign red_sum     = {1'b0, red_rem_reg} + R_FRAC;
    assign red_wrap    = red_sum >= LIMIT;
    assign green_sum   = {1'b0, green_rem_reg} + G_FRAC;
    assign green_wrap  = green_sum >= LIMIT;
    assign blue_borrow = {1'b0, blue_rem_reg} < B_FRAC;

    always_comb
    begin
        red_q_next     = red_q_reg;
        red_rem_next   = red_rem_reg;
        green_q_next   = green_q_reg;
        green_rem_next = green_rem_reg;
        blue_q_next    = blue_q_reg;
        blue_rem_next  = blue_rem_reg;
        if (init)
        begin
            red_q_next     = '0;
            red_rem_next   = '0;
            green_q_next   = GREEN_W'(GREEN_BASE);
            green_rem_next = '0;
            blue_q_next    = BLUE_W'(BLUE_SCALE);
            blue_rem_next  = '0;
        end
        else if (step)
        begin
            red_rem_next   = red_wrap ? NW'(red_sum - LIMIT) : NW'(red_sum);
            red_q_next     = red_q_reg + R_STEP + RED_W'(red_wrap);
            green_rem_next = green_wrap ? NW'(green_sum - LIMIT) : NW'(green_sum);
            green_q_next   = green_q_reg + G_STEP + GREEN_W'(green_wrap);
            // blue counts down from full scale
            blue_rem_next  = blue_borrow ? NW'({1'b0, blue_rem_reg} + LIMIT - B_FRAC)
                                         : NW'({1'b0, blue_rem_reg} - B_FRAC);
            blue_q_next    = blue_q_reg - B_STEP - BLUE_W'(blue_borrow);
        end
    end

    always_ff @(posedge clk)
    begin
        red_q_reg     <= red_q_next;
        red_rem_reg   <= red_rem_next;
        green_q_reg   <= green_q_next;
        green_rem_reg <= green_rem_next;
        blue_q_reg    <= blue_q_next;
        blue_rem_reg  <= blue_rem_next;
    end

    assign red   = red_q_reg;
    assign green = green_q_reg;
    assign blue  = blue_q_reg;

endmodule

FILE: rtl/mandelbrot_escape_time_pixel_core.sv
// top level of the mandelbrot escape-time pixel core
//
// Evaluates one pixel per input beat: (pixel_x, pixel_y) is mapped onto the
// complex plane as cr = x*2.47/width - 2 and ci = y*2.24/height - 1.12 in
// signed fixed point with FRAC_BITS fraction bits (rounded toward minus
// infinity), then z = z*z + c is iterated from zero until |z|^2 exceeds 4
// or MAX_ITERATIONS steps have run. The result beat carries the step count
// n and a linear color ramp derived from n. One pixel is in flight at a
// time; in_ready is high only while the core is idle, and a finished result
// waits in the output register without blocking the next input beat. The
// two coordinates are produced side by side by bit-serial dividers, one
// quotient bit a cycle, and each iteration then passes through the shared
// iteration unit in the check state, which fires its three registered
// multipliers, and the update state, which does the escape compare and the
// update of z. A width or height register of zero acts as one. The user
// must write the registers only while the core is idle; the core itself
// does not enforce this.
module mandelbrot_escape_time_pixel_core #(
    parameter int MAX_ITERATIONS = 50,
    parameter int FRAC_BITS      = 26,
    parameter int COORD_BITS     = 12
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // register write port
    input  logic                            cfg_write_en,
    input  mbe_pkg::cfg_index_t             cfg_index,
    input  logic [mbe_pkg::CFG_W-1:0]       cfg_data,
    // pixel input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [COORD_BITS-1:0]           pixel_x,
    input  logic [COORD_BITS-1:0]           pixel_y,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mbe_pkg::COUNT_W-1:0]     iteration_count,
    output logic [mbe_pkg::RED_W-1:0]       red,
    output logic [mbe_pkg::GREEN_W-1:0]     green,
    output logic [mbe_pkg::BLUE_W-1:0]      blue
);
    import mbe_pkg::*;

    localparam int QW = COORD_BITS + FRAC_BITS + 2;
    localparam int NW = $clog2(MAX_ITERATIONS + 1);
    localparam logic [NW-1:0] LIMIT = NW'(MAX_ITERATIONS);

    // configuration
    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;

    // sequencer
    state_t         state_reg, state_next;
    logic [NW-1:0]  count_reg, count_next;
    iter_ctrl_t     iter_ctrl;
    iter_stat_t     iter_stat;
    logic           ramp_init;
    logic           ramp_step;
    logic           result_load;
    logic           in_beat;

    // coordinate mappers
    logic                busy_x;
    logic                busy_y;
    logic                map_busy;
    logic signed [QW:0]  cr;
    logic signed [QW:0]  ci;

    // ramp values
    logic [RED_W-1:0]    ramp_red;
    logic [GREEN_W-1:0]  ramp_green;
    logic [BLUE_W-1:0]   ramp_blue;

    // output register
    logic                out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0]  count_out_reg;
    logic [RED_W-1:0]    red_reg;
    logic [GREEN_W-1:0]  green_reg;
    logic [BLUE_W-1:0]   blue_reg;

    // register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = cfg_data;
                CFG_IMAGE_HEIGHT: height_next = cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign in_beat  = in_valid && in_ready;
    assign map_busy = busy_x || busy_y;

    // x and y lanes start together on the accepted beat
    mbe_map #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SCALE      (X_SCALE),
        .OFFSET     (X_OFFSET)
    ) u_map_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_beat),
        .coord (pixel_x),
        .size  (width_reg),
        .busy  (busy_x),
        .value (cr)
    );

    mbe_map #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .SCALE      (Y_SCALE),
        .OFFSET     (Y_OFFSET)
    ) u_map_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_beat),
        .coord (pixel_y),
        .size  (height_reg),
        .busy  (busy_y),
        .value (ci)
    );

    mbe_iter #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_iter (
        .clk   (clk),
        .ctrl  (iter_ctrl),
        .cr_in (cr),
        .ci_in (ci),
        .stat  (iter_stat)
    );

    mbe_ramp #(
        .MAX_ITERATIONS (MAX_ITERATIONS)
    ) u_ramp (
        .clk   (clk),
        .init  (ramp_init),
        .step  (ramp_step),
        .red   (ramp_red),
        .green (ramp_green),
        .blue  (ramp_blue)
    );

    // sequencer: map, then check / multiply and compare / update per step
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        iter_ctrl   = '0;
        ramp_init   = 1'b0;
        ramp_step   = 1'b0;
        result_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                // both coordinates ready: seed z and the ramp
                if (!map_busy)
                begin
                    iter_ctrl.load = 1'b1;
                    ramp_init      = 1'b1;
                    count_next     = '0;
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                // limit reached or a component already beyond two
                if ((count_reg == LIMIT) || iter_stat.out_of_range)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    iter_ctrl.mult = 1'b1;
                    state_next     = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (iter_stat.escaped)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    iter_ctrl.update = 1'b1;
                    ramp_step        = 1'b1;
                    count_next       = count_reg + NW'(1);
                    state_next       = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || out_ready)
                begin
                    result_load = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            // count keeps only its low bits for large limits
            count_out_reg <= COUNT_W'(count_reg);
            red_reg       <= ramp_red;
            green_reg     <= ramp_green;
            blue_reg      <= ramp_blue;
        end
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = count_out_reg;
    assign red             = red_reg;
    assign green           = green_reg;
    assign blue            = blue_reg;

`ifndef ASSERT_OFF
    // step counter never runs past the limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LIMIT)
        else $error("iteration count beyond limit");

    // dividers only run while the sequencer waits on them
    a_map_owned: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MAP) |-> !map_busy)
        else $error("coordinate mapper busy outside map phase");

    // an accepted beat starts both mappers at once
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> ((state_reg == ST_MAP) && busy_x && busy_y))
        else $error("accepted beat did not start mapping");

    // a new result only leaves the done state
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        result_load |-> (state_reg == ST_DONE))
        else $error("result loaded outside done state");
`endif

endmodule
